@@ rtl/core/bard_pkg.sv @@
// ----------------------------------------------------------------------------
// Bus address region decoder package
// Shared widths, kind and status codes, and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bard_pkg;

   localparam int unsigned NUM_TARGETS = 4;
   localparam int unsigned NUM_ENTRIES = 16;
   localparam int unsigned ENTRY_W     = $clog2(NUM_ENTRIES);

   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned TGT_W    = 4;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_DECODE = 2'd1,
      KIND_UNMAP  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_MISS   = 3'd2,
      ST_BADTGT = 3'd3,
      ST_RANGE  = 3'd4
   } status_type;

   typedef struct packed {
      logic [TGT_W-1:0]    target;
      logic [ADDR_W-1:0]   address_out;
      logic [SLOT_W-1:0]   entry_slot;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/bus_address_region_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Bus address region decoder core
// Region table with insert, decode and unmap operations, one word per cycle while not stalled.
// ----------------------------------------------------------------------------
// Path: an accepted request word is registered in the request register, decoded
//   from there, and its response waits in the response register until taken.
// Throughput: one word per cycle while responses drain; all region compares
//   run in parallel between the request register and the response register.
// Reset: clears both valid flags and frees every region (size, mode and
//   target cleared); region bases are not reset and are written by inserts.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_address_region_decoder_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [bard_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [bard_pkg::ADDR_W-1:0]   req_address,
   input  wire logic [bard_pkg::ADDR_W-1:0]   req_region_length,
   input  wire logic                          req_relative_mode,
   input  wire logic                          req_target_given,
   input  wire logic [bard_pkg::TGT_W-1:0]    req_target_index,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bard_pkg::TGT_W-1:0]         rsp_target,
   output logic [bard_pkg::ADDR_W-1:0]        rsp_address_out,
   output logic [bard_pkg::SLOT_W-1:0]        rsp_entry_slot,
   output logic [bard_pkg::STATUS_W-1:0]      rsp_status
);
   import bard_pkg::*;

   // request register
   logic                in_valid_ff;
   logic [KIND_W-1:0]   in_kind_ff;
   logic [ADDR_W-1:0]   in_addr_ff;
   logic [ADDR_W-1:0]   in_len_ff;
   logic                in_rel_ff;
   logic                in_given_ff;
   logic [TGT_W-1:0]    in_tidx_ff;

   // response register
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   // region table
   logic [ADDR_W-1:0]   region_base_ff     [NUM_ENTRIES];
   logic [ADDR_W-1:0]   region_size_ff     [NUM_ENTRIES];
   logic                region_relative_ff [NUM_ENTRIES];
   logic [TGT_W-1:0]    region_target_ff   [NUM_ENTRIES];

   // per-entry decode lanes
   logic [NUM_ENTRIES-1:0] hit;
   logic [ADDR_W-1:0]      lane_off [NUM_ENTRIES];

   logic                   free_found;
   logic [ENTRY_W-1:0]     free_idx;
   logic                   hit_found;
   logic [ENTRY_W-1:0]     hit_idx;
   logic                   tidx_bad;
   logic [ENTRY_W-1:0]     unmap_idx;
   logic                   advance;
   logic                   do_insert;

   // Advance the registered request into the response register whenever the
   // response slot is empty or being drained this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign do_insert = advance && (kind_type'(in_kind_ff) == KIND_INSERT) && free_found;

   // Region hit per entry: half-open range [base, base + size), formed as
   // (addr - base) < size so the end sum never overflows.
   always_comb begin
      logic [ADDR_W-1:0] diff;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         diff        = in_addr_ff - region_base_ff[i];
         hit[i]      = (region_size_ff[i] != '0) && (in_addr_ff >= region_base_ff[i]) &&
                       (diff < region_size_ff[i]);
         lane_off[i] = region_relative_ff[i] ? diff : in_addr_ff;
      end
   end

   // Lowest free entry and lowest hit entry.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      hit_found  = 1'b0;
      hit_idx    = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (!free_found && (region_size_ff[i] == '0)) begin
            free_found = 1'b1;
            free_idx   = ENTRY_W'(i);
         end
         if (!hit_found && hit[i]) begin
            hit_found = 1'b1;
            hit_idx   = ENTRY_W'(i);
         end
      end
   end

   // Unmap entry check: the number must name both a target and an entry.
   assign tidx_bad  = (32'(in_tidx_ff) >= NUM_TARGETS) || (32'(in_tidx_ff) >= NUM_ENTRIES);
   assign unmap_idx = ENTRY_W'(in_tidx_ff);

   // Build the response word.
   always_comb begin
      rsp_in = '0;
      case (kind_type'(in_kind_ff))
         KIND_INSERT: begin
            if (free_found) begin
               rsp_in.entry_slot = SLOT_W'(free_idx);
               rsp_in.status     = ST_OK;
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         KIND_DECODE: begin
            if (hit_found) begin
               rsp_in.target      = region_target_ff[hit_idx];
               rsp_in.address_out = lane_off[hit_idx];
               rsp_in.status      = ST_OK;
            end else begin
               rsp_in.address_out = in_addr_ff;
               rsp_in.status      = ST_MISS;
            end
         end
         KIND_UNMAP: begin
            if (tidx_bad) begin
               rsp_in.status = ST_BADTGT;
            end else if (region_relative_ff[unmap_idx]) begin
               if (in_addr_ff >= region_size_ff[unmap_idx]) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  rsp_in.address_out = region_base_ff[unmap_idx] + in_addr_ff;
               end
            end else begin
               rsp_in.address_out = in_addr_ff;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Request register: load on accept, drop the valid flag once advanced.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_kind_ff  <= req_kind;
         in_addr_ff  <= req_address;
         in_len_ff   <= req_region_length;
         in_rel_ff   <= req_relative_mode;
         in_given_ff <= req_target_given;
         in_tidx_ff  <= req_target_index;
      end
   end

   // Response register: hold until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Region size, mode and target: cleared by reset, written by an insert.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            region_size_ff[i]     <= '0;
            region_relative_ff[i] <= 1'b0;
            region_target_ff[i]   <= '0;
         end
      end else if (do_insert) begin
         region_size_ff[free_idx]     <= in_len_ff;
         region_relative_ff[free_idx] <= in_rel_ff;
         region_target_ff[free_idx]   <= in_given_ff ? in_tidx_ff : TGT_W'(free_idx);
      end
   end

   // Region base: read only for a written entry, so it carries no reset.
   always_ff @(posedge clock) begin
      if (do_insert) begin
         region_base_ff[free_idx] <= in_addr_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target      = rsp_ff.target;
   assign rsp_address_out = rsp_ff.address_out;
   assign rsp_entry_slot  = rsp_ff.entry_slot;
   assign rsp_status      = rsp_ff.status;

endmodule

`default_nettype wire

@@ dv/bus_address_region_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// Bus address region decoder core testbench
// Drives insert, decode, unmap and unused-kind words through the request
// channel with random idle cycles on both sides and one long response stall.
// A local copy of the region table predicts each response word unless a row is typed,
// and the response monitor checks each word field by field in order of arrival.
// ----------------------------------------------------------------------------
module bus_address_region_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bard_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned RANDOM_WORDS = 850;
   localparam int unsigned IDLE_PCT     = 8;
   // Receiver stops draining once this many responses have arrived, for a
   // stretch set by HOLD_CYCLES, while the sender keeps offering words.
   localparam int unsigned HOLD_AFTER   = 200;
   localparam int unsigned HOLD_CYCLES  = 80;
   // Stretch of words (sender) and responses (receiver) with no idling.
   localparam int unsigned QUIET_FROM   = 400;
   localparam int unsigned QUIET_TO     = 550;
   localparam int unsigned DRAIN_CYCLES = 10;

   // One request word, plus an optional hand-typed response for the
   // directed rows whose outcome is obvious.
   typedef struct {
      kind_type          kind;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] length;
      logic              relative;
      logic              given;
      logic [TGT_W-1:0]  tgt_index;
      bit                typed;
      rsp_type           want;
   } req_word_type;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind          = '0;
   logic [ADDR_W-1:0]     req_address       = '0;
   logic [ADDR_W-1:0]     req_region_length = '0;
   logic                  req_relative_mode = 1'b0;
   logic                  req_target_given  = 1'b0;
   logic [TGT_W-1:0]      req_target_index  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [TGT_W-1:0]      rsp_target;
   logic [ADDR_W-1:0]     rsp_address_out;
   logic [SLOT_W-1:0]     rsp_entry_slot;
   logic [STATUS_W-1:0]   rsp_status;

   // Local copy of the region table; a zero size marks a free entry.
   logic [ADDR_W-1:0]     base_tbl [NUM_ENTRIES];
   logic [ADDR_W-1:0]     size_tbl [NUM_ENTRIES];
   logic                  rel_tbl  [NUM_ENTRIES];
   logic [TGT_W-1:0]      tgt_tbl  [NUM_ENTRIES];

   rsp_type               rsp_due_q [$];
   req_word_type          directed_words [$];
   int                    fail_count = 0;
   int                    rsp_count  = 0;
   int                    kind_hits   [4];
   int                    status_hits [8];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bus_address_region_decoder_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .req_region_length (req_region_length),
      .req_relative_mode (req_relative_mode),
      .req_target_given  (req_target_given),
      .req_target_index  (req_target_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_target        (rsp_target),
      .rsp_address_out   (rsp_address_out),
      .rsp_entry_slot    (rsp_entry_slot),
      .rsp_status        (rsp_status)
   );

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Apply one accepted word to the local region table and return the
   // response word it must produce.
   function automatic rsp_type region_table_apply(req_word_type w);
      rsp_type r;
      int      slot;
      r    = '0;
      slot = -1;
      case (w.kind)
         KIND_INSERT: begin
            // Take the lowest free entry; a zero-length insert leaves it free.
            for (int i = 0; i < NUM_ENTRIES; i++)
               if (slot < 0 && size_tbl[i] == '0) slot = i;
            if (slot < 0) begin
               r.status = ST_FULL;
            end else begin
               base_tbl[slot] = w.address;
               size_tbl[slot] = w.length;
               rel_tbl[slot]  = w.relative;
               tgt_tbl[slot]  = w.given ? w.tgt_index : TGT_W'(slot);
               r.entry_slot   = SLOT_W'(slot);
               r.status       = ST_OK;
            end
         end
         KIND_DECODE: begin
            // Lowest entry wins; the region end is exclusive and the sum
            // base + size is never formed.
            for (int i = 0; i < NUM_ENTRIES; i++)
               if (slot < 0 && size_tbl[i] != '0 && w.address >= base_tbl[i] &&
                   w.address - base_tbl[i] < size_tbl[i]) slot = i;
            if (slot < 0) begin
               r.address_out = w.address;
               r.status      = ST_MISS;
            end else begin
               r.target      = tgt_tbl[slot];
               r.address_out = rel_tbl[slot] ? w.address - base_tbl[slot] : w.address;
               r.status      = ST_OK;
            end
         end
         KIND_UNMAP: begin
            if (w.tgt_index >= NUM_TARGETS || w.tgt_index >= NUM_ENTRIES) begin
               r.status = ST_BADTGT;
            end else if (rel_tbl[w.tgt_index]) begin
               if (w.address >= size_tbl[w.tgt_index]) begin
                  r.status = ST_RANGE;
               end else begin
                  r.address_out = base_tbl[w.tgt_index] + w.address;
                  r.status      = ST_OK;
               end
            end else begin
               // Absolute or free entry: hand the offset back unchanged.
               r.address_out = w.address;
               r.status      = ST_OK;
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic add_row(kind_type k, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] len,
                          logic rel, logic given, logic [TGT_W-1:0] idx, bit typed,
                          logic [TGT_W-1:0] e_tgt, logic [ADDR_W-1:0] e_addr,
                          logic [SLOT_W-1:0] e_slot, status_type e_st);
      req_word_type w;
      w.kind             = k;
      w.address          = a;
      w.length           = len;
      w.relative         = rel;
      w.given            = given;
      w.tgt_index        = idx;
      w.typed            = typed;
      w.want.target      = e_tgt;
      w.want.address_out = e_addr;
      w.want.entry_slot  = e_slot;
      w.want.status      = e_st;
      directed_words.push_back(w);
   endtask

   // Build a random word. Most decodes and unmaps aim at live regions and
   // their edges; inserts are mostly zero length so the table fills slowly
   // and the full-table case shows up late in the run.
   function automatic req_word_type random_word();
      req_word_type      w;
      int                live [$];
      int                e;
      int                pick;
      logic [ADDR_W-1:0] off;
      w.kind      = KIND_NONE;
      w.address   = rand64();
      w.length    = rand64();
      w.relative  = 1'($urandom_range(1));
      w.given     = 1'($urandom_range(1));
      w.tgt_index = TGT_W'($urandom_range(15));
      w.typed     = 1'b0;
      w.want      = '0;
      pick        = $urandom_range(99);
      if (pick < 20) begin
         w.kind = KIND_INSERT;
         if ($urandom_range(7) == 0) begin
            case ($urandom_range(9))
               0:       w.length = '1;
               1:       w.length = rand64();
               2:       w.length = rand64() >> $urandom_range(63);
               default: w.length = ADDR_W'($urandom_range(65536, 1));
            endcase
         end else begin
            w.length = '0;
         end
         if ($urandom_range(4) == 0) w.address = '1 - ADDR_W'($urandom_range(255));
      end else if (pick < 70) begin
         w.kind = KIND_DECODE;
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (size_tbl[i] != '0) live.push_back(i);
         if (live.size() != 0 && $urandom_range(9) < 8) begin
            e = live[$urandom_range(live.size() - 1)];
            case ($urandom_range(4))
               0:       off = '0;
               1:       off = size_tbl[e] - 1;
               2:       off = size_tbl[e];
               3:       off = '1;
               default: off = rand64() % size_tbl[e];
            endcase
            w.address = base_tbl[e] + off;
         end
      end else if (pick < 95) begin
         w.kind = KIND_UNMAP;
         if ($urandom_range(9) != 0) w.tgt_index = TGT_W'($urandom_range(NUM_TARGETS - 1));
         if (rel_tbl[w.tgt_index] && size_tbl[w.tgt_index] != '0) begin
            case ($urandom_range(4))
               0:       w.address = '0;
               1:       w.address = size_tbl[w.tgt_index] - 1;
               2:       w.address = size_tbl[w.tgt_index];
               3:       w.address = rand64() % size_tbl[w.tgt_index];
               default: w.address = rand64();
            endcase
         end
      end
      return w;
   endfunction

   // Offer one word, idling at random first unless in the quiet stretch.
   // Hold valid and payload until the handshake, then log the response due.
   task automatic drive_word(req_word_type w, bit quiet);
      rsp_type due;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= w.kind;
      req_address       <= w.address;
      req_region_length <= w.length;
      req_relative_mode <= w.relative;
      req_target_given  <= w.given;
      req_target_index  <= w.tgt_index;
      do @(posedge clock); while (req_ready !== 1'b1);
      due = region_table_apply(w);
      if (w.typed) due = w.want;
      rsp_due_q.push_back(due);
      kind_hits[w.kind]++;
      status_hits[due.status]++;
   endtask

   // Receiver: stall at random, drain without gaps in the quiet stretch, and
   // hold off once for a long stretch so the block backs up into req_ready.
   initial begin : rsp_drain
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && rsp_count >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (rsp_count >= QUIET_FROM && rsp_count < QUIET_TO) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Response monitor: compare every accepted word with the oldest one due.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (rsp_due_q.size() == 0) begin
            $error("response word with none due: target %0h address_out %0h status %0d",
                   rsp_target, rsp_address_out, rsp_status);
            fail_count++;
         end else begin
            want = rsp_due_q.pop_front();
            if (rsp_target !== want.target) begin
               $error("target: expected %0h, got %0h", want.target, rsp_target);
               fail_count++;
            end
            if (rsp_address_out !== want.address_out) begin
               $error("address_out: expected %0h, got %0h", want.address_out, rsp_address_out);
               fail_count++;
            end
            if (rsp_entry_slot !== want.entry_slot) begin
               $error("entry_slot: expected %0h, got %0h", want.entry_slot, rsp_entry_slot);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      // Clear the local table to match reset: every entry free.
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         base_tbl[i] = '0;
         size_tbl[i] = '0;
         rel_tbl[i]  = 1'b0;
         tgt_tbl[i]  = '0;
      end

      // Directed rows. Columns: kind, address, length, relative, given, index,
      // typed, then target, address_out, entry_slot, status when typed.
      // Empty table: decodes miss at both address extremes, an unmap of a free
      // absolute entry passes the offset through, bad entry numbers, unused kind.
      add_row(KIND_DECODE, '0, '0, 0, 0, 0, 1, 0, '0, 0, ST_MISS);
      add_row(KIND_DECODE, '1, '1, 1, 1, 15, 1, 0, '1, 0, ST_MISS);
      add_row(KIND_UNMAP, 64'h5, '0, 0, 0, 0, 1, 0, 64'h5, 0, ST_OK);
      add_row(KIND_UNMAP, 64'h5, '0, 0, 0, 4, 1, 0, '0, 0, ST_BADTGT);
      add_row(KIND_UNMAP, '1, '1, 1, 1, 15, 1, 0, '0, 0, ST_BADTGT);
      add_row(KIND_NONE, '1, '1, 1, 1, 15, 1, 0, '0, 0, ST_OK);
      // Relative region at 0x1000, target taken from the entry number; probe
      // both edges and one past each end.
      add_row(KIND_INSERT, 64'h1000, 64'h100, 1, 0, 9, 1, 0, '0, 0, ST_OK);
      add_row(KIND_DECODE, 64'h1000, '0, 0, 0, 0, 0, 0, '0, 0, ST_OK);
      add_row(KIND_DECODE, 64'h10FF, '0, 0, 0, 0, 0, 0, '0, 0, ST_OK);
      add_row(KIND_DECODE, 64'h1100, '0, 0, 0, 0, 0, 0, '0, 0, ST_OK);
      add_row(KIND_DECODE, 64'h0FFF, '0, 0, 0, 0, 0, 0, '0, 0, ST_OK);
      // Zero-length insert: reported, but the entry stays free and relative,
      // so an unmap on it is out of range and the next insert reuses it.
      add_row(KIND_INSERT, 64'h2000, '0, 1, 1, 15, 1, 0, '0, 1, ST_OK);
      add_row(KIND_UNMAP, '0, '0, 0, 0, 1, 1, 0, '0, 0, ST_RANGE);
      add_row(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 64'h100, 0, 1, 3, 1, 0, '0, 1, ST_OK);
      add_row(KIND_DECODE, '1, '0, 0, 0, 0, 0, 0, '0, 0, ST_OK);
      // Top-most base with all-ones length; offsets near the top wrap.
      add_row(KIND_INSERT, '1, '1, 1, 1, 2, 1, 0, '0, 2, ST_OK);
      add_row(KIND_UNMAP, '1, '0, 0, 0, 2, 1, 0, '0, 0, ST_RANGE);
      add_row(KIND_UNMAP, 64'hFFFF_FFFF_FFFF_FFFE, '0, 0, 0, 2, 0, 0, '0, 0, ST_OK);
      add_row(KIND_UNMAP, 64'h80, '0, 0, 0, 0, 0, 0, '0, 0, ST_OK);
      add_row(KIND_UNMAP, 64'h100, '0, 0, 0, 0, 1, 0, '0, 0, ST_RANGE);
      add_row(KIND_UNMAP, 64'h1234, '0, 0, 0, 1, 0, 0, '0, 0, ST_OK);
      // Region whose end wraps past zero: only addresses above the base hit,
      // and overlap with a lower entry resolves to the lower one.
      add_row(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 64'h40, 1, 0, 0, 1, 0, '0, 3, ST_OK);
      add_row(KIND_DECODE, 64'h10, '0, 0, 0, 0, 0, 0, '0, 0, ST_OK);
      add_row(KIND_UNMAP, 64'h20, '0, 0, 0, 3, 0, 0, '0, 0, ST_OK);
      add_row(KIND_DECODE, 64'hFFFF_FFFF_FFFF_FFF8, '0, 0, 0, 0, 0, 0, '0, 0, ST_OK);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_words[i]) drive_word(directed_words[i], 1'b0);
      for (int n = 0; n < RANDOM_WORDS; n++)
         drive_word(random_word(), n >= QUIET_FROM && n < QUIET_TO);
      req_valid <= 1'b0;

      // Wait for every response due, then let the pipeline settle.
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d words: %0d insert, %0d decode, %0d unmap, %0d unused kind",
               kind_hits[0] + kind_hits[1] + kind_hits[2] + kind_hits[3],
               kind_hits[KIND_INSERT], kind_hits[KIND_DECODE], kind_hits[KIND_UNMAP],
               kind_hits[KIND_NONE]);
      $display("Statuses: %0d ok, %0d table full, %0d miss, %0d bad target, %0d out of range",
               status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_MISS],
               status_hits[ST_BADTGT], status_hits[ST_RANGE]);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
